// ===== src/spd_pkg.sv =====
// Package: types, packet type codes and field decode helpers for the sensor packet decoder.
package spd_pkg;

    typedef logic [7:0]         byte_t;
    typedef logic [3:0]         kind_t;
    typedef logic signed [12:0] value_a_t;
    typedef logic signed [16:0] value_b_t;
    typedef logic signed [10:0] value_c_t;
    typedef logic [31:0]        packet_t;

    // Packet type codes carried in bits 3..0 of a packet
    localparam logic [3:0] PT_INFRARED   = 4'd1;
    localparam logic [3:0] PT_ULTRASONIC = 4'd2;
    localparam logic [3:0] PT_YAW        = 4'd3;
    localparam logic [3:0] PT_MAG        = 4'd4;
    localparam logic [3:0] PT_GYRO       = 4'd5;
    localparam logic [3:0] PT_RAZOR_ACC  = 4'd6;
    localparam logic [3:0] PT_BOARD_ACC  = 4'd7;
    localparam logic [3:0] PT_POSITION   = 4'd10;
    localparam logic [3:0] PT_PATH       = 4'd11;
    localparam logic [3:0] PT_VELOCITY   = 4'd12;
    localparam logic [3:0] PT_HEADING    = 4'd13;

    // Result kinds
    localparam kind_t KIND_INFRARED   = 4'd0;
    localparam kind_t KIND_ULTRASONIC = 4'd1;
    localparam kind_t KIND_YAW        = 4'd2;
    localparam kind_t KIND_MAG        = 4'd3;
    localparam kind_t KIND_GYRO       = 4'd4;
    localparam kind_t KIND_RAZOR_ACC  = 4'd5;
    localparam kind_t KIND_BOARD_ACC  = 4'd6;
    localparam kind_t KIND_POSITION   = 4'd7;
    localparam kind_t KIND_PATH       = 4'd8;
    localparam kind_t KIND_VELOCITY   = 4'd9;
    localparam kind_t KIND_HEADING    = 4'd10;

    localparam logic [4:0]  IR_NO_READING = 5'd31;
    localparam logic [9:0]  US_NO_READING = 10'd630;
    localparam logic [10:0] HEADING_WRAP  = 11'd2000;

    // Ultrasonic scale codes
    localparam logic [1:0] US_SCALE_X1  = 2'd0;
    localparam logic [1:0] US_SCALE_X3  = 2'd1;
    localparam logic [1:0] US_SCALE_X5  = 2'd2;
    localparam logic [1:0] US_SCALE_X10 = 2'd3;

    // Sign-magnitude to two's complement; a negative zero comes out as zero
    function automatic value_b_t sign_mag(input logic [15:0] mag, input logic neg);
        value_b_t m;
        m = value_b_t'({1'b0, mag});
        return neg ? -m : m;
    endfunction

    function automatic value_c_t ir_value(input logic [4:0] v);
        return (v == IR_NO_READING) ? -11'sd1 : value_c_t'({6'd0, v});
    endfunction

    function automatic value_c_t us_value(input logic [5:0] v, input logic [1:0] code);
        logic [9:0] p;
        case (code)
            US_SCALE_X1:  p = {4'd0, v};
            US_SCALE_X3:  p = {4'd0, v} + {3'd0, v, 1'b0};
            US_SCALE_X5:  p = {4'd0, v} + {2'd0, v, 2'b0};
            US_SCALE_X10: p = {3'd0, v, 1'b0} + {1'd0, v, 3'b0};
            default:      p = {4'd0, v};
        endcase
        return (p == US_NO_READING) ? -11'sd1 : value_c_t'({1'b0, p});
    endfunction

endpackage

// ===== src/sensor_packet_decoder_unit.sv =====
// Top level: byte assembler and packet decoder with registered result.
//
// The block takes one received byte per cycle on the rx channel, unless the
// res channel holds it back, and groups every four bytes, most significant
// first, into a 32-bit packet. The packet is held in a packet register and
// decoded on the next stage into the result register when the stages advance.
// Sustained rate is one byte per cycle while results are taken, set by the
// single packet register and the result register; both advance together
// whenever the result register is empty or being taken.
// Packet types that only log (0, 8, 9, 14, 15) produce no result, and the
// first three bytes of a packet never do. Bits 31..30 are not checked.
// value_b is zero for yaw and heading, value_c is zero for all kinds other
// than infrared and ultrasonic. A no-reading code is reported as -1.
module sensor_packet_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  spd_pkg::byte_t      rx_byte,
    output logic                res_valid,
    input  logic                res_ready,
    output spd_pkg::kind_t      kind,
    output spd_pkg::value_a_t   value_a,
    output spd_pkg::value_b_t   value_b,
    output spd_pkg::value_c_t   value_c
);
    import spd_pkg::*;

    // Byte assembly
    logic [1:0]  byte_count_reg, byte_count_next;
    logic [23:0] held_bytes_reg, held_bytes_next;

    // Packet stage
    logic        pkt_valid_reg, pkt_valid_next;
    packet_t     pkt_reg, pkt_next;

    // Result stage
    logic        res_valid_reg, res_valid_next;
    kind_t       kind_reg;
    value_a_t    value_a_reg;
    value_b_t    value_b_reg;
    value_c_t    value_c_reg;

    // Decoder output
    logic        dec_emit;
    kind_t       dec_kind;
    value_a_t    dec_a;
    value_b_t    dec_b;
    value_c_t    dec_c;

    logic        stage_adv;
    logic        rx_fire;
    logic        last_byte;
    value_b_t    sm_a;
    value_b_t    sm_b;
    logic [10:0] heading_raw;

    // Both stages move when the result slot is free or being drained
    assign stage_adv = !res_valid_reg || res_ready;
    assign rx_ready  = !pkt_valid_reg || stage_adv;
    assign rx_fire   = rx_valid && rx_ready;
    assign last_byte = (byte_count_reg == 2'd3);

    // Collect bytes; on the fourth one hand the whole packet to the packet stage
    always_comb
    begin
        byte_count_next = byte_count_reg;
        held_bytes_next = held_bytes_reg;
        pkt_next        = pkt_reg;
        pkt_valid_next  = pkt_valid_reg && !stage_adv;
        if (rx_fire)
        begin
            if (last_byte)
            begin
                byte_count_next = 2'd0;
                held_bytes_next = 24'd0;
                pkt_next        = {held_bytes_reg, rx_byte};
                pkt_valid_next  = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_reg + 2'd1;
                held_bytes_next = {held_bytes_reg[15:0], rx_byte};
            end
        end
    end

    // Decode the held packet
    always_comb
    begin
        dec_emit    = 1'b1;
        dec_kind    = KIND_INFRARED;
        dec_a       = '0;
        dec_b       = '0;
        dec_c       = '0;
        sm_a        = '0;
        sm_b        = '0;
        heading_raw = pkt_reg[14:4];
        case (pkt_reg[3:0])
            PT_INFRARED:
            begin
                dec_kind = KIND_INFRARED;
                dec_a    = value_a_t'(ir_value(pkt_reg[8:4]));
                dec_b    = value_b_t'(ir_value(pkt_reg[13:9]));
                dec_c    = ir_value(pkt_reg[18:14]);
            end
            PT_ULTRASONIC:
            begin
                dec_kind = KIND_ULTRASONIC;
                dec_a    = value_a_t'(us_value(pkt_reg[9:4], pkt_reg[11:10]));
                dec_b    = value_b_t'(us_value(pkt_reg[17:12], pkt_reg[19:18]));
                dec_c    = us_value(pkt_reg[25:20], pkt_reg[27:26]);
            end
            PT_YAW:
            begin
                dec_kind = KIND_YAW;
                sm_a     = sign_mag({8'd0, pkt_reg[11:4]}, pkt_reg[12]);
                dec_a    = sm_a[12:0];
            end
            PT_MAG, PT_GYRO, PT_RAZOR_ACC, PT_BOARD_ACC:
            begin
                dec_kind = pkt_reg[3:0] - 4'd1;
                sm_a     = sign_mag({8'd0, pkt_reg[11:4]}, pkt_reg[12]);
                sm_b     = sign_mag({8'd0, pkt_reg[20:13]}, pkt_reg[21]);
                dec_a    = sm_a[12:0];
                dec_b    = sm_b;
            end
            PT_POSITION:
            begin
                dec_kind = KIND_POSITION;
                sm_a     = sign_mag({4'd0, pkt_reg[15:4]}, pkt_reg[16]);
                sm_b     = sign_mag({4'd0, pkt_reg[28:17]}, pkt_reg[29]);
                dec_a    = sm_a[12:0];
                dec_b    = sm_b;
            end
            PT_PATH:
            begin
                dec_kind = KIND_PATH;
                dec_a    = value_a_t'({7'd0, pkt_reg[9:4]});
                dec_b    = value_b_t'({1'b0, pkt_reg[25:10]});
            end
            PT_VELOCITY:
            begin
                dec_kind = KIND_VELOCITY;
                sm_a     = sign_mag({7'd0, pkt_reg[12:4]}, pkt_reg[13]);
                sm_b     = sign_mag({7'd0, pkt_reg[22:14]}, pkt_reg[23]);
                dec_a    = sm_a[12:0];
                dec_b    = sm_b;
            end
            PT_HEADING:
            begin
                dec_kind = KIND_HEADING;
                // The raw value stays below twice the wrap, one subtract suffices
                if (heading_raw >= HEADING_WRAP)
                begin
                    dec_a = value_a_t'({2'd0, heading_raw - HEADING_WRAP});
                end
                else
                begin
                    dec_a = value_a_t'({2'd0, heading_raw});
                end
            end
            default:
            begin
                // Log-only packet: drop it
                dec_emit = 1'b0;
            end
        endcase
    end

    // Result slot fills from the packet stage whenever the stages advance
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (stage_adv)
        begin
            res_valid_next = pkt_valid_reg && dec_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 2'd0;
            held_bytes_reg <= 24'd0;
            pkt_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            held_bytes_reg <= held_bytes_next;
            pkt_valid_reg  <= pkt_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
        if (stage_adv)
        begin
            kind_reg    <= dec_kind;
            value_a_reg <= dec_a;
            value_b_reg <= dec_b;
            value_c_reg <= dec_c;
        end
    end

    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign value_a   = value_a_reg;
    assign value_b   = value_b_reg;
    assign value_c   = value_c_reg;

endmodule

// ===== verif/sensor_packet_decoder_unit_tb.sv =====
// Testbench: byte stream stimulus, decode prediction and result checking for the packet decoder.
`timescale 1ns / 1ps

module sensor_packet_decoder_unit_tb;

    import spd_pkg::*;

    // One decoded sensor reading as it leaves the result channel
    typedef struct packed {
        kind_t    kind;
        value_a_t value_a;
        value_b_t value_b;
        value_c_t value_c;
    } reading_t;

    localparam int RANDOM_BYTES  = 1500;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 27;
    // Window of cycles in which neither side idles
    localparam int CALM_FROM     = 1000;
    localparam int CALM_TO       = 1600;
    localparam int DRAIN_CYCLES  = 8;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     rx_valid = 1'b0;
    logic     rx_ready;
    byte_t    rx_byte = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    kind_t    kind;
    value_a_t value_a;
    value_b_t value_b;
    value_c_t value_c;

    byte_t    tx_bytes[$];
    reading_t expected_readings[$];
    int       total_bytes = 0;
    int       bytes_taken = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    // Packet assembly state, mirrored from the byte stream the block takes
    logic [1:0]  frame_fill = '0;
    logic [23:0] frame_bytes = '0;

    sensor_packet_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .value_a   (value_a),
        .value_b   (value_b),
        .value_c   (value_c)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Decode prediction
    // ------------------------------------------------------------------

    function automatic int ir_reading(input logic [4:0] v);
        return (v == IR_NO_READING) ? -1 : int'(v);
    endfunction

    // Field is six bits of distance followed by a two bit scale code
    function automatic int us_reading(input logic [7:0] f);
        int scale;
        int prod;
        case (f[7:6])
            US_SCALE_X1:  scale = 1;
            US_SCALE_X3:  scale = 3;
            US_SCALE_X5:  scale = 5;
            default:      scale = 10;
        endcase
        prod = int'(f[5:0]) * scale;
        return (prod == int'(US_NO_READING)) ? -1 : prod;
    endfunction

    // A set sign on a zero magnitude still gives zero
    function automatic int signed_mag(input int unsigned mag, input logic neg);
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // Returns 1 when the packet type carries a reading, 0 for log-only types
    function automatic bit decode_packet(input packet_t p, output reading_t r);
        r = '0;
        case (p[3:0])
            PT_INFRARED: begin
                r.kind    = KIND_INFRARED;
                r.value_a = value_a_t'(ir_reading(p[8:4]));
                r.value_b = value_b_t'(ir_reading(p[13:9]));
                r.value_c = value_c_t'(ir_reading(p[18:14]));
            end
            PT_ULTRASONIC: begin
                r.kind    = KIND_ULTRASONIC;
                r.value_a = value_a_t'(us_reading(p[11:4]));
                r.value_b = value_b_t'(us_reading(p[19:12]));
                r.value_c = value_c_t'(us_reading(p[27:20]));
            end
            PT_YAW: begin
                r.kind    = KIND_YAW;
                r.value_a = value_a_t'(signed_mag(32'(p[11:4]), p[12]));
            end
            PT_MAG, PT_GYRO, PT_RAZOR_ACC, PT_BOARD_ACC: begin
                case (p[3:0])
                    PT_MAG:       r.kind = KIND_MAG;
                    PT_GYRO:      r.kind = KIND_GYRO;
                    PT_RAZOR_ACC: r.kind = KIND_RAZOR_ACC;
                    default:      r.kind = KIND_BOARD_ACC;
                endcase
                r.value_a = value_a_t'(signed_mag(32'(p[11:4]), p[12]));
                r.value_b = value_b_t'(signed_mag(32'(p[20:13]), p[21]));
            end
            PT_POSITION: begin
                r.kind    = KIND_POSITION;
                r.value_a = value_a_t'(signed_mag(32'(p[15:4]), p[16]));
                r.value_b = value_b_t'(signed_mag(32'(p[28:17]), p[29]));
            end
            PT_PATH: begin
                r.kind    = KIND_PATH;
                r.value_a = value_a_t'(p[9:4]);
                r.value_b = value_b_t'({1'b0, p[25:10]});
            end
            PT_VELOCITY: begin
                r.kind    = KIND_VELOCITY;
                r.value_a = value_a_t'(signed_mag(32'(p[12:4]), p[13]));
                r.value_b = value_b_t'(signed_mag(32'(p[22:14]), p[23]));
            end
            PT_HEADING: begin
                r.kind    = KIND_HEADING;
                r.value_a = value_a_t'(int'(p[14:4]) % int'(HEADING_WRAP));
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic packet_t place(input packet_t p, input int pos, input int w,
                                      input int unsigned v);
        for (int i = 0; i < w; i++)
            p[pos + i] = v[i];
        return p;
    endfunction

    // Favor the field extremes: zero, all ones, otherwise random
    function automatic int unsigned corner(input int w);
        int unsigned mask;
        mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    // Random packet: random type and background bits, decoded fields
    // pushed toward their corners so special values show up often
    function automatic packet_t random_packet();
        packet_t p;
        int      pos;
        p = $urandom;
        p[3:0] = 4'($urandom_range(0, 15));
        case (p[3:0])
            PT_INFRARED:
                for (int i = 0; i < 3; i++)
                    p = place(p, 4 + 5 * i, 5, corner(5));
            PT_ULTRASONIC:
                for (int i = 0; i < 3; i++) begin
                    pos = 4 + 8 * i;
                    // Hit the no-reading product now and then
                    if ($urandom_range(0, 3) == 0)
                        p = place(p, pos, 8, 32'({US_SCALE_X10, 6'd63}));
                    else
                        p = place(p, pos, 6, corner(6));
                end
            PT_YAW, PT_MAG, PT_GYRO, PT_RAZOR_ACC, PT_BOARD_ACC: begin
                p = place(p, 4, 8, corner(8));
                p = place(p, 13, 8, corner(8));
            end
            PT_POSITION: begin
                p = place(p, 4, 12, corner(12));
                p = place(p, 17, 12, corner(12));
            end
            PT_PATH: begin
                p = place(p, 4, 6, corner(6));
                p = place(p, 10, 16, corner(16));
            end
            PT_VELOCITY: begin
                p = place(p, 4, 9, corner(9));
                p = place(p, 14, 9, corner(9));
            end
            PT_HEADING:
                // Half the time land from one below the wrap point up to the top of the field
                if ($urandom_range(0, 1) == 0)
                    p = place(p, 4, 11, $urandom_range(1999, 2047));
                else
                    p = place(p, 4, 11, corner(11));
            default: ;
        endcase
        return p;
    endfunction

    // Queue a packet, most significant byte first
    task automatic queue_packet(input packet_t p);
        for (int i = 3; i >= 0; i--)
            tx_bytes = {tx_bytes, p[8 * i +: 8]};
        total_bytes += 4;
    endtask

    // ------------------------------------------------------------------
    // Cycle counter and timeout
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit calm();
        return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: feeds the rx channel from the pending queue and
    // predicts a reading each time a packet of a reading type completes
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        reading_t r;
        packet_t  p;
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= '0;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                // Item taken: advance the packet assembly
                bytes_taken++;
                if (frame_fill != 2'd3)
                begin
                    frame_bytes = {frame_bytes[15:0], rx_byte};
                    frame_fill  = frame_fill + 2'd1;
                end
                else
                begin
                    p           = {frame_bytes, rx_byte};
                    frame_bytes = '0;
                    frame_fill  = '0;
                    if (decode_packet(p, r))
                        expected_readings = {expected_readings, r};
                end
            end
            // Hold an offered item until it is taken; otherwise offer the
            // next one unless this cycle idles
            if (!rx_valid || rx_ready)
            begin
                if (tx_bytes.size() != 0
                    && (calm() || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= tx_bytes.pop_front();
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, compare each reading with the
    // oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected reading kind=%0d a=%0d b=%0d c=%0d",
                             $time, kind, value_a, value_b, value_c);
                    error_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, kind);
                        error_count++;
                    end
                    if (value_a !== want.value_a)
                    begin
                        $display("%0t: value_a expected %0d actual %0d",
                                 $time, want.value_a, value_a);
                        error_count++;
                    end
                    if (value_b !== want.value_b)
                    begin
                        $display("%0t: value_b expected %0d actual %0d",
                                 $time, want.value_b, value_b);
                        error_count++;
                    end
                    if (value_c !== want.value_c)
                    begin
                        $display("%0t: value_c expected %0d actual %0d",
                                 $time, want.value_c, value_c);
                        error_count++;
                    end
                end
            end
            res_ready <= calm() || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        packet_t p;

        // Directed packets, some with background bits set so the terminator bits
        // and unused bits are exercised too
        // Infrared: zero, one below no-reading, no-reading
        p = 32'hFFFF_FFF0 | PT_INFRARED;
        p = place(p, 4, 5, 0);
        p = place(p, 9, 5, 30);
        p = place(p, 14, 5, 32'(IR_NO_READING));
        queue_packet(p);
        // Ultrasonic: 63 x10 is the no-reading product, 63 x5, 0 x3
        p = 32'hC000_0000 | PT_ULTRASONIC;
        p = place(p, 4, 8, 32'({US_SCALE_X10, 6'd63}));
        p = place(p, 12, 8, 32'({US_SCALE_X5, 6'd63}));
        p = place(p, 20, 8, 32'({US_SCALE_X3, 6'd0}));
        queue_packet(p);
        // Yaw with negative zero
        p = 32'h0000_0000 | PT_YAW;
        p = place(p, 12, 1, 1);
        queue_packet(p);
        // Magnetometer at full scale, both signs
        p = 32'h0000_0000 | PT_MAG;
        p = place(p, 4, 9, 32'h1FF);
        p = place(p, 13, 9, 32'h0FF);
        queue_packet(p);
        // Position: largest negative x, negative zero y
        p = 32'h0000_0000 | PT_POSITION;
        p = place(p, 4, 13, 32'h1FFF);
        p = place(p, 17, 13, 32'h1000);
        queue_packet(p);
        // Heading at the top of its range wraps to 47
        p = 32'hFFFF_FFF0 | PT_HEADING;
        queue_packet(p);
        // Log-only type, all ones: consumed, nothing emitted
        queue_packet(32'hFFFF_FFFF);

        while (total_bytes < RANDOM_BYTES + 28)
            queue_packet(random_packet());

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n = 1'b1;

        // Drain: every byte taken and every prediction checked
        while (bytes_taken != total_bytes || expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/spd_pkg.sv
src/sensor_packet_decoder_unit.sv
verif/sensor_packet_decoder_unit_tb.sv
